// File: design/brbp_pkg.sv
// Shared types and codes for the byte ring buffer with peek.
// Used by the controller, the datapath, the top level and the checker.
package brbp_pkg;

   // Default sizes handed to the top level parameters
   localparam int DEPTH_DEF     = 1024;
   localparam int MAX_BURST_DEF = 64;

   // Request kinds
   typedef enum logic [2:0] {
      KIND_APPEND  = 3'd0,
      KIND_PREPEND = 3'd1,
      KIND_GET     = 3'd2,
      KIND_REMOVE  = 3'd3,
      KIND_PEEK    = 3'd4,
      KIND_SEEK    = 3'd5,
      KIND_CURSOR  = 3'd6,
      KIND_CLEAR   = 3'd7
   } kind_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_NOSPACE = 3'd2,
      ST_NODATA  = 3'd3,
      ST_BADLEN  = 3'd4
   } status_type;

   // Open block tracking
   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_APPEND  = 2'd1,
      MODE_PREPEND = 2'd2,
      MODE_DROP    = 2'd3
   } mode_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_SEND = 3'b100
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;     // take the request item this cycle
      logic csr_we;     // write the capacity register
      logic rd_issue;   // read the next burst byte from the store
      logic rsp_load;   // load the response register
      logic rsp_burst;  // response comes from the store read data
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic burst;       // request item yields a byte burst
      logic rsp_free;    // response register can take an item
      logic burst_last;  // current burst byte is the final one
   } sts_type;

endpackage

// File: design/byte_ring_buffer_with_peek.sv
// Top level of the byte ring buffer with peek: joins controller and datapath.
// Depends on brbp_pkg, brbp_ctrl and brbp_datapath.
//
//   port group  direction  handshake           carries
//   req_*       in         req_valid/stall     one request item
//   rsp_*       out        rsp_valid/stall     one result item
//   csr_*       in         csr_valid/ready     capacity register value
//
// Append, prepend, remove, seek, cursor reset and clear load their result in
// the cycle they are accepted, as do get and peek items that deliver no byte.
// Get and peek that deliver bytes, after the accept cycle, take per byte a
// store read, then the load of the response register, which waits while the
// result cannot move; the registered read port splits the read from the load.
// Reset is synchronous and clears pointers, counts and the block tracking;
// the byte store is not cleared, so there is no clearing pass after reset.
// A stalled result holds its register; new requests wait until it can move,
// and also while a capacity write is offered.
module byte_ring_buffer_with_peek #(
   parameter int DEPTH     = brbp_pkg::DEPTH_DEF,
   parameter int MAX_BURST = brbp_pkg::MAX_BURST_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic [10:0] req_length,
   input  logic        req_first_of_block,
   input  logic [11:0] req_seek_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_data_byte_res,
   output logic        rsp_last,
   output logic [10:0] rsp_moved_count,
   output logic [10:0] rsp_free_space,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_capacity
);
   import brbp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencing
   brbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage and arithmetic
   brbp_datapath #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_kind           (req_kind),
      .req_data_byte      (req_data_byte),
      .req_length         (req_length),
      .req_first_of_block (req_first_of_block),
      .req_seek_offset    (req_seek_offset),
      .csr_capacity       (csr_capacity),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_data_byte_res  (rsp_data_byte_res),
      .rsp_last           (rsp_last),
      .rsp_moved_count    (rsp_moved_count),
      .rsp_free_space     (rsp_free_space),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

// File: design/brbp_ctrl.sv
// Controller for the byte ring buffer: one-hot state machine that sequences
// request intake and get/peek bursts. Depends on brbp_pkg.
module brbp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  brbp_pkg::sts_type  sts,
   output brbp_pkg::cmd_type  cmd
);
   import brbp_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next state and commands; hold requests while a capacity write is offered
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      csr_ready  = (state_ff == S_IDLE);
      cmd.csr_we = csr_valid && csr_ready;
      req_stall  = !((state_ff == S_IDLE) && sts.rsp_free && !csr_valid);
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.accept = 1'b1;
               if (sts.burst) begin
                  state_in = S_READ;
               end else begin
                  cmd.rsp_load = 1'b1;
               end
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (sts.rsp_free) begin
               cmd.rsp_load  = 1'b1;
               cmd.rsp_burst = 1'b1;
               state_in      = sts.burst_last ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/brbp_datapath.sv
// Datapath for the byte ring buffer: pointers, fill and cursor, block
// tracking, byte store, burst counters and response register. Uses brbp_pkg.
module brbp_datapath #(
   parameter int DEPTH     = brbp_pkg::DEPTH_DEF,
   parameter int MAX_BURST = brbp_pkg::MAX_BURST_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_kind,
   input  logic [7:0]         req_data_byte,
   input  logic [10:0]        req_length,
   input  logic               req_first_of_block,
   input  logic [11:0]        req_seek_offset,
   input  logic [10:0]        csr_capacity,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_data_byte_res,
   output logic               rsp_last,
   output logic [10:0]        rsp_moved_count,
   output logic [10:0]        rsp_free_space,
   input  brbp_pkg::cmd_type  cmd,
   output brbp_pkg::sts_type  sts
);
   import brbp_pkg::*;

   localparam int PW  = $clog2(DEPTH);
   localparam int CW0 = $clog2(DEPTH + 1);
   localparam int CW  = (CW0 > 11) ? CW0 : 11;
   localparam int BW  = $clog2(MAX_BURST + 1);

   // (a + b) mod cap, for a < cap and b <= cap
   function automatic logic [CW-1:0] add_mod(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b,
                                             input logic [CW-1:0] cap);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, cap}) begin
         s = s - {1'b0, cap};
      end
      return s[CW-1:0];
   endfunction

   // (a - b) mod cap, for a < cap and b <= cap
   function automatic logic [CW-1:0] sub_mod(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b,
                                             input logic [CW-1:0] cap);
      logic [CW-1:0] r;
      if (a >= b) begin
         r = a - b;
      end else begin
         r = a + (cap - b);
      end
      return r;
   endfunction

   // State registers
   logic [CW-1:0] cap_ff, cap_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] cur_ff, cur_in;
   mode_type      mode_ff, mode_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic [PW-1:0] pp_ff, pp_in;
   logic [CW-1:0] total_ff, total_in;
   status_type    berr_ff, berr_in;

   // Burst and response registers
   logic [PW-1:0] addr_ff;
   logic [BW-1:0] left_ff;
   logic [10:0]   bn_ff;
   logic [7:0]    rd_data_ff;
   logic          rsp_valid_ff;
   status_type    rsp_status_ff;
   logic [7:0]    rsp_data_ff;
   logic          rsp_last_ff;
   logic [10:0]   rsp_moved_ff;
   logic [10:0]   rsp_free_ff;

   logic [7:0] mem [DEPTH];

   // Item decode results
   logic          we;
   logic [PW-1:0] waddr;
   status_type    st_c;
   logic [10:0]   moved_c;
   logic          burst_c;
   logic [CW-1:0] bstart_c;
   logic [CW-1:0] bn_c;

   // Working values of the item update
   kind_type             kind;
   logic [CW-1:0]        len_x;
   logic [CW-1:0]        rp_x;
   logic [CW-1:0]        wp_x;
   logic [CW-1:0]        free_x;
   logic [CW-1:0]        avail;
   logic [CW-1:0]        n;
   logic                 do_write;
   mode_type             m;
   logic [CW-1:0]        r;
   logic [CW-1:0]        p;
   logic [CW-1:0]        t;
   logic [CW-1:0]        capv;
   logic signed [CW+1:0] pos;
   logic signed [CW+1:0] off_x;

   assign kind   = kind_type'(req_kind);
   assign len_x  = CW'(req_length);
   assign rp_x   = CW'(rp_ff);
   assign wp_x   = CW'(wp_ff);
   assign free_x = cap_ff - fill_ff;
   assign off_x  = {{(CW - 10){req_seek_offset[11]}}, req_seek_offset};

   // Work out the effect of one request item or a capacity write
   always_comb begin
      cap_in    = cap_ff;
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      cur_in    = cur_ff;
      mode_in   = mode_ff;
      remain_in = remain_ff;
      pp_in     = pp_ff;
      total_in  = total_ff;
      berr_in   = berr_ff;
      we        = 1'b0;
      waddr     = wp_ff;
      st_c      = ST_OK;
      moved_c   = '0;
      burst_c   = 1'b0;
      bstart_c  = rp_x;
      bn_c      = '0;
      avail     = '0;
      n         = '0;
      do_write  = 1'b0;
      m         = mode_ff;
      r         = remain_ff;
      p         = CW'(pp_ff);
      t         = total_ff;
      capv      = '0;
      pos       = '0;
      if (cmd.csr_we) begin
         // clamp capacity and empty the buffer
         capv = CW'(csr_capacity);
         if (capv == '0) begin
            capv = CW'(1);
         end else if (capv > CW'(DEPTH)) begin
            capv = CW'(DEPTH);
         end
         cap_in    = capv;
         rp_in     = '0;
         wp_in     = '0;
         fill_in   = '0;
         cur_in    = '0;
         mode_in   = MODE_IDLE;
         remain_in = '0;
      end else if (cmd.accept) begin
         case (kind)
            KIND_APPEND, KIND_PREPEND: begin
               if (req_first_of_block) begin
                  // new block: check it whole before storing anything
                  mode_in   = MODE_IDLE;
                  remain_in = '0;
                  if (len_x == '0) begin
                     st_c = ST_BADLEN;
                  end else if (fill_ff >= cap_ff || free_x < len_x) begin
                     berr_in   = (fill_ff >= cap_ff) ? ST_FULL : ST_NOSPACE;
                     remain_in = len_x - CW'(1);
                     mode_in   = (len_x != CW'(1)) ? MODE_DROP : MODE_IDLE;
                     st_c      = (fill_ff >= cap_ff) ? ST_FULL : ST_NOSPACE;
                  end else begin
                     m = (kind == KIND_PREPEND) ? MODE_PREPEND : MODE_APPEND;
                     t = len_x;
                     r = len_x;
                     if (kind == KIND_PREPEND) begin
                        p = sub_mod(rp_x, len_x, cap_ff);
                     end
                     do_write = 1'b1;
                  end
               end else if (mode_ff == MODE_DROP && remain_ff != '0) begin
                  // drop the rest of a failed block
                  remain_in = remain_ff - CW'(1);
                  if (remain_ff == CW'(1)) begin
                     mode_in = MODE_IDLE;
                  end
                  st_c = berr_ff;
               end else if (!(remain_ff != '0 &&
                              ((mode_ff == MODE_APPEND && kind == KIND_APPEND) ||
                               (mode_ff == MODE_PREPEND && kind == KIND_PREPEND)))) begin
                  // stray continuation byte
                  mode_in   = MODE_IDLE;
                  remain_in = '0;
                  st_c      = ST_BADLEN;
               end else begin
                  do_write = 1'b1;
               end
               if (do_write) begin
                  we = 1'b1;
                  if (m == MODE_APPEND) begin
                     waddr   = wp_ff;
                     wp_in   = PW'(add_mod(wp_x, CW'(1), cap_ff));
                     fill_in = fill_ff + CW'(1);
                  end else begin
                     waddr = PW'(p);
                     p     = add_mod(p, CW'(1), cap_ff);
                  end
                  r = r - CW'(1);
                  if (r == '0) begin
                     if (m == MODE_PREPEND) begin
                        rp_in   = PW'(sub_mod(rp_x, t, cap_ff));
                        fill_in = fill_ff + t;
                        cur_in  = '0;
                     end
                     m = MODE_IDLE;
                  end
                  mode_in   = m;
                  remain_in = r;
                  pp_in     = PW'(p);
                  total_in  = t;
                  moved_c   = 11'd1;
               end
            end
            KIND_GET, KIND_REMOVE: begin
               mode_in   = MODE_IDLE;
               remain_in = '0;
               if (len_x == '0) begin
                  st_c = ST_BADLEN;
               end else if (fill_ff == '0) begin
                  st_c = ST_NODATA;
               end else begin
                  n = (len_x < fill_ff) ? len_x : fill_ff;
                  if (kind == KIND_GET && n > CW'(MAX_BURST)) begin
                     n = CW'(MAX_BURST);
                  end
                  rp_in   = PW'(add_mod(rp_x, n, cap_ff));
                  fill_in = fill_ff - n;
                  cur_in  = '0;
                  moved_c = n[10:0];
                  if (kind == KIND_GET) begin
                     burst_c  = 1'b1;
                     bstart_c = rp_x;
                     bn_c     = n;
                  end
               end
            end
            KIND_PEEK: begin
               mode_in   = MODE_IDLE;
               remain_in = '0;
               avail     = (fill_ff > cur_ff) ? (fill_ff - cur_ff) : '0;
               if (len_x == '0) begin
                  st_c = ST_BADLEN;
               end else if (avail == '0) begin
                  st_c = ST_NODATA;
               end else begin
                  n = (len_x < avail) ? len_x : avail;
                  if (n > CW'(MAX_BURST)) begin
                     n = CW'(MAX_BURST);
                  end
                  burst_c  = 1'b1;
                  bstart_c = add_mod(rp_x, cur_ff, cap_ff);
                  bn_c     = n;
               end
            end
            KIND_SEEK: begin
               // move the cursor, saturated to the held bytes
               mode_in   = MODE_IDLE;
               remain_in = '0;
               pos       = $signed({2'b00, cur_ff}) + off_x;
               if (pos < 0) begin
                  cur_in = '0;
               end else if (pos > $signed({2'b00, fill_ff})) begin
                  cur_in = fill_ff;
               end else begin
                  cur_in = pos[CW-1:0];
               end
            end
            KIND_CURSOR: begin
               mode_in   = MODE_IDLE;
               remain_in = '0;
               cur_in    = '0;
            end
            KIND_CLEAR: begin
               rp_in     = '0;
               wp_in     = '0;
               fill_in   = '0;
               cur_in    = '0;
               mode_in   = MODE_IDLE;
               remain_in = '0;
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   assign sts.burst      = burst_c;
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign sts.burst_last = (left_ff == '0);

   // Buffer state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CW'(DEPTH);
         rp_ff     <= '0;
         wp_ff     <= '0;
         fill_ff   <= '0;
         cur_ff    <= '0;
         mode_ff   <= MODE_IDLE;
         remain_ff <= '0;
         pp_ff     <= '0;
         total_ff  <= '0;
         berr_ff   <= ST_OK;
      end else begin
         cap_ff    <= cap_in;
         rp_ff     <= rp_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         cur_ff    <= cur_in;
         mode_ff   <= mode_in;
         remain_ff <= remain_in;
         pp_ff     <= pp_in;
         total_ff  <= total_in;
         berr_ff   <= berr_in;
      end
   end

   // Byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= req_data_byte;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[addr_ff];
      end
   end

   // Burst address and count
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (cmd.accept && burst_c) begin
         addr_ff <= PW'(bstart_c);
         left_ff <= BW'(bn_c);
         bn_ff   <= bn_c[10:0];
      end else if (cmd.rd_issue) begin
         addr_ff <= PW'(add_mod(CW'(addr_ff), CW'(1), cap_ff));
         left_ff <= left_ff - BW'(1);
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_free_ff <= 11'(cap_in - fill_in);
         if (cmd.rsp_burst) begin
            rsp_status_ff <= ST_OK;
            rsp_data_ff   <= rd_data_ff;
            rsp_last_ff   <= (left_ff == '0);
            rsp_moved_ff  <= bn_ff;
         end else begin
            rsp_status_ff <= st_c;
            rsp_data_ff   <= '0;
            rsp_last_ff   <= 1'b1;
            rsp_moved_ff  <= moved_c;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_data_byte_res = rsp_data_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_moved_count   = rsp_moved_ff;
   assign rsp_free_space    = rsp_free_ff;

endmodule

// File: design/brbp_checker.sv
// Port-level checks for the byte ring buffer with peek, bound to the top level.
// Depends on brbp_pkg and byte_ring_buffer_with_peek.
module brbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_kind,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_data_byte_res,
   input logic        rsp_last,
   input logic [10:0] rsp_moved_count
);
   import brbp_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_data_byte_res) && $stable(rsp_last) && $stable(rsp_moved_count))
      else $error("stalled result changed");

   // Drop all results on reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Single-result items answer in the next cycle
   a_single_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind != KIND_GET && req_kind != KIND_PEEK
         |=> rsp_valid && rsp_last)
      else $error("single result item not answered in next cycle");

   // Only a successful burst gives results that are not last
   a_burst_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == ST_OK && rsp_moved_count > 11'd1)
      else $error("non-final result outside a burst");

endmodule

bind byte_ring_buffer_with_peek brbp_checker u_brbp_checker (.*);
